// ----- hdl/sed_pkg.sv -----
// ----------------------------------------------------------------------------
// sed_pkg
// types, codes and helpers shared by the string escape decoder files
// ----------------------------------------------------------------------------
package sed_pkg;

    localparam logic [7:0] CHAR_BACKSLASH = 8'h5c;
    localparam logic [7:0] CHAR_DQUOTE    = 8'h22;
    localparam logic [7:0] CHAR_R         = 8'h72;
    localparam logic [7:0] CHAR_N         = 8'h6e;
    localparam logic [7:0] CHAR_ZERO      = 8'h30;
    localparam logic [7:0] CHAR_T         = 8'h74;
    localparam logic [7:0] CHAR_X         = 8'h78;

    localparam logic [7:0] BYTE_CR  = 8'h0d;
    localparam logic [7:0] BYTE_LF  = 8'h0a;
    localparam logic [7:0] BYTE_NUL = 8'h00;
    localparam logic [7:0] BYTE_TAB = 8'h09;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_DANGLING = 2'd1,
        ST_BAD_HEX  = 2'd2,
        ST_UNKNOWN  = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        MODE_NORMAL = 4'b0001,
        MODE_ESCAPE = 4'b0010,
        MODE_HEX_HI = 4'b0100,
        MODE_HEX_LO = 4'b1000
    } mode_t;

    typedef struct packed {
        logic [7:0] in_char;
        logic       is_final;
    } in_word_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        status_t    status;
        logic       string_done;
    } out_word_t;

    // nibble value, bad flag set when the character is not a hex digit
    typedef struct packed {
        logic       bad;
        logic [3:0] value;
    } hex_digit_t;

    function automatic hex_digit_t hex_decode(input logic [7:0] c);
        hex_digit_t d;
        d.bad   = 1'b0;
        d.value = 4'd0;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            d.value = c[3:0];
        end
        else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
        begin
            d.value = c[3:0] + 4'd9;
        end
        else
        begin
            d.bad = 1'b1;
        end
        return d;
    endfunction

endpackage

// ----- hdl/sed_if.sv -----
// ----------------------------------------------------------------------------
// sed_if
// valid/ready channels carrying character words in and decoded words out
// ----------------------------------------------------------------------------
interface sed_in_if
    import sed_pkg::*;
(
    input logic clk
);
    logic       valid;
    logic       ready;
    logic [7:0] in_char;
    logic       is_final;

    modport source (output valid, output in_char, output is_final, input ready);
    modport sink   (input valid, input in_char, input is_final, output ready);
endinterface

interface sed_out_if
    import sed_pkg::*;
(
    input logic clk
);
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       byte_valid;
    status_t    status;
    logic       string_done;

    modport source (output valid, output out_byte, output byte_valid, output status,
                    output string_done, input ready);
    modport sink   (input valid, input out_byte, input byte_valid, input status,
                    input string_done, output ready);
endinterface

// ----- hdl/string_escape_decoder_unit.sv -----
// ----------------------------------------------------------------------------
// string_escape_decoder_unit
// decodes backslash escapes of a string literal body, one character a cycle
// ----------------------------------------------------------------------------
// Takes one character word per clock while the output is not stalled: a
// word sits in the input register, is decoded against the escape mode
// register and lands in the result register. Words that complete nothing
// (a backslash, an "x", the first hex digit, characters after an error) give
// no output word. Status is reported once, on the word that fails; the word
// flagged is_final always closes the string with string_done and returns the
// decoder to its reset state. The output register may hold a word while the
// next one is accepted; backpressure holds the result register, and the input
// register fills with one more word and then holds as well.
module string_escape_decoder_unit
    import sed_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    sed_in_if.sink    in_ch,
    sed_out_if.source out_ch
);

    logic       in_valid_reg;
    in_word_t   in_word_reg;
    logic       out_valid_reg;
    out_word_t  out_word_reg;

    mode_t      mode_reg;
    mode_t      mode_next;
    logic [3:0] high_nibble_reg;
    logic [3:0] high_nibble_next;
    logic       high_bad_reg;
    logic       high_bad_next;
    logic       failed_reg;
    logic       failed_next;

    logic       advance;
    logic       emit;
    out_word_t  result;
    hex_digit_t digit;
    logic [7:0] dec_byte;
    logic       dec_valid;
    status_t    dec_status;

    assign advance      = !out_valid_reg || out_ch.ready;
    assign in_ch.ready  = !in_valid_reg || advance;
    assign digit        = hex_decode(in_word_reg.in_char);

    always_comb
    begin
        mode_next        = mode_reg;
        high_nibble_next = high_nibble_reg;
        high_bad_next    = high_bad_reg;
        failed_next      = failed_reg;
        dec_byte         = 8'd0;
        dec_valid        = 1'b0;
        dec_status       = ST_OK;
        if (!failed_reg)
        begin
            unique case (mode_reg)
                MODE_NORMAL:
                begin
                    if (in_word_reg.in_char == CHAR_BACKSLASH)
                    begin
                        if (in_word_reg.is_final)
                            dec_status = ST_DANGLING;
                        else
                            mode_next = MODE_ESCAPE;
                    end
                    else
                    begin
                        dec_byte  = in_word_reg.in_char;
                        dec_valid = 1'b1;
                    end
                end
                MODE_ESCAPE:
                begin
                    mode_next = MODE_NORMAL;
                    dec_valid = 1'b1;
                    unique case (in_word_reg.in_char)
                        CHAR_BACKSLASH: dec_byte = CHAR_BACKSLASH;
                        CHAR_DQUOTE:    dec_byte = CHAR_DQUOTE;
                        CHAR_R:         dec_byte = BYTE_CR;
                        CHAR_N:         dec_byte = BYTE_LF;
                        CHAR_ZERO:      dec_byte = BYTE_NUL;
                        CHAR_T:         dec_byte = BYTE_TAB;
                        CHAR_X:
                        begin
                            dec_valid = 1'b0;
                            if (in_word_reg.is_final)
                                dec_status = ST_DANGLING;
                            else
                                mode_next = MODE_HEX_HI;
                        end
                        default:
                        begin
                            dec_valid  = 1'b0;
                            dec_status = ST_UNKNOWN;
                        end
                    endcase
                end
                MODE_HEX_HI:
                begin
                    if (in_word_reg.is_final)
                    begin
                        dec_status = ST_DANGLING;
                    end
                    else
                    begin
                        high_nibble_next = digit.value;
                        high_bad_next    = digit.bad;
                        mode_next        = MODE_HEX_LO;
                    end
                end
                MODE_HEX_LO:
                begin
                    mode_next = MODE_NORMAL;
                    if (high_bad_reg || digit.bad)
                    begin
                        dec_status = ST_BAD_HEX;
                    end
                    else
                    begin
                        dec_byte  = {high_nibble_reg, digit.value};
                        dec_valid = 1'b1;
                    end
                end
                default:
                begin
                    mode_next = MODE_NORMAL;
                end
            endcase
            if (dec_status != ST_OK)
            begin
                failed_next = 1'b1;
                mode_next   = MODE_NORMAL;
            end
        end
        // end of string returns everything to reset
        if (in_word_reg.is_final)
        begin
            mode_next        = MODE_NORMAL;
            high_nibble_next = 4'd0;
            high_bad_next    = 1'b0;
            failed_next      = 1'b0;
        end
    end

    assign emit               = dec_valid || (dec_status != ST_OK) || in_word_reg.is_final;
    assign result.out_byte    = dec_byte;
    assign result.byte_valid  = dec_valid;
    assign result.status      = dec_status;
    assign result.string_done = in_word_reg.is_final;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            mode_reg        <= MODE_NORMAL;
            high_nibble_reg <= 4'd0;
            high_bad_reg    <= 1'b0;
            failed_reg      <= 1'b0;
        end
        else
        begin
            if (in_ch.ready)
                in_valid_reg <= in_ch.valid;
            if (advance)
                out_valid_reg <= in_valid_reg && emit;
            if (advance && in_valid_reg)
            begin
                mode_reg        <= mode_next;
                high_nibble_reg <= high_nibble_next;
                high_bad_reg    <= high_bad_next;
                failed_reg      <= failed_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.ready && in_ch.valid)
        begin
            in_word_reg.in_char  <= in_ch.in_char;
            in_word_reg.is_final <= in_ch.is_final;
        end
        if (advance && in_valid_reg && emit)
            out_word_reg <= result;
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.out_byte    = out_word_reg.out_byte;
    assign out_ch.byte_valid  = out_word_reg.byte_valid;
    assign out_ch.status      = out_word_reg.status;
    assign out_ch.string_done = out_word_reg.string_done;

endmodule

// ----- hdl/sed_checker.sv -----
// ----------------------------------------------------------------------------
// sed_checker
// port-level checks on the string escape decoder output channel
// ----------------------------------------------------------------------------
module sed_checker
    import sed_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_byte,
    input logic       byte_valid,
    input logic [1:0] status,
    input logic       string_done
);

    // stalled word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(byte_valid)
            && $stable(status) && $stable(string_done))
        else $error("stalled output word changed");

    // an error word carries no byte
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_OK |-> !byte_valid && out_byte == 8'd0)
        else $error("error word carries a byte");

    // every word has a reason: a byte, an error or the end of the string
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> byte_valid || status != ST_OK || string_done)
        else $error("empty output word");

    // no word straight out of reset
    assert property (@(posedge clk)
        $rose(rst_n) |-> !out_valid)
        else $error("output word right after reset");

endmodule

bind string_escape_decoder_unit sed_checker u_sed_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .out_byte    (out_ch.out_byte),
    .byte_valid  (out_ch.byte_valid),
    .status      (out_ch.status),
    .string_done (out_ch.string_done)
);

// ----- verif/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the string escape decoder unit
// ----------------------------------------------------------------------------
// Character words are queued by an initial block and sent by a clocked
// driver. The driver runs a bit-accurate copy of the escape decoder on every
// accepted word and queues the expected output words. A clocked monitor
// compares each accepted output word with the oldest one queued. Both sides
// idle at random, with a stretch of full throughput, and the driver once
// holds a string back until all queued output words have come out.
// ----------------------------------------------------------------------------
module tb_top;
    import sed_pkg::*;

    localparam int RAND_ITEMS     = 1200;
    localparam int DRAIN_AT       = 800;
    localparam int IDLE_PCT       = 37;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int TAIL_CYCLES    = 8;

    localparam logic [7:0] ESC_LETTERS [6] = '{CHAR_BACKSLASH, CHAR_DQUOTE, CHAR_R,
                                              CHAR_N, CHAR_ZERO, CHAR_T};

    typedef struct {
        in_word_t word;
        bit       drain;
    } pending_word_t;

    logic clk;
    logic rst_n;

    sed_in_if  in_ch (clk);
    sed_out_if out_ch (clk);

    string_escape_decoder_unit DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    pending_word_t pending_words [$];
    out_word_t     expected_words [$];
    logic [7:0]    str_buf [$];

    // decoder copy
    mode_t      esc_mode;
    logic [3:0] hi_nib;
    logic       hi_bad;
    logic       failed;

    int  n_sent;
    int  errors;
    bit  drain_placed;
    logic calm;

    out_word_t     head_word;
    pending_word_t next_word;

    assign calm = (n_sent >= 300) && (n_sent < 550);

    always #5 clk = ~clk;

    // {bad, value}
    function automatic logic [4:0] nibble_of(input logic [7:0] c);
        if (c >= CHAR_ZERO && c <= 8'h39)
            return {1'b0, 4'(c - CHAR_ZERO)};
        else if (c >= 8'h61 && c <= 8'h66)
            return {1'b0, 4'(c - 8'h57)};
        else if (c >= 8'h41 && c <= 8'h46)
            return {1'b0, 4'(c - 8'h37)};
        return 5'b10000;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] v, input logic upper);
        if (v < 4'd10)
            return CHAR_ZERO + 8'(v);
        return (upper ? 8'h41 : 8'h61) + 8'(v) - 8'd10;
    endfunction

    function automatic logic [7:0] non_hex_char();
        logic [7:0] c;
        logic [4:0] d;
        do
        begin
            c = 8'($urandom_range(0, 255));
            d = nibble_of(c);
        end
        while (!d[4]);
        return c;
    endfunction

    task automatic clear_decoder();
        esc_mode = MODE_NORMAL;
        hi_nib   = 4'd0;
        hi_bad   = 1'b0;
        failed   = 1'b0;
    endtask

    task automatic decode_char(input logic [7:0] c, input logic fin);
        out_word_t  r;
        logic [4:0] d;
        r.out_byte    = 8'd0;
        r.byte_valid  = 1'b0;
        r.status      = ST_OK;
        r.string_done = fin;
        if (!failed)
        begin
            case (esc_mode)
                MODE_NORMAL:
                begin
                    if (c == CHAR_BACKSLASH)
                    begin
                        if (fin)
                            r.status = ST_DANGLING;
                        else
                            esc_mode = MODE_ESCAPE;
                    end
                    else
                    begin
                        r.out_byte   = c;
                        r.byte_valid = 1'b1;
                    end
                end
                MODE_ESCAPE:
                begin
                    esc_mode     = MODE_NORMAL;
                    r.byte_valid = 1'b1;
                    case (c)
                        CHAR_BACKSLASH: r.out_byte = CHAR_BACKSLASH;
                        CHAR_DQUOTE:    r.out_byte = CHAR_DQUOTE;
                        CHAR_R:         r.out_byte = BYTE_CR;
                        CHAR_N:         r.out_byte = BYTE_LF;
                        CHAR_ZERO:      r.out_byte = BYTE_NUL;
                        CHAR_T:         r.out_byte = BYTE_TAB;
                        CHAR_X:
                        begin
                            r.byte_valid = 1'b0;
                            if (fin)
                                r.status = ST_DANGLING;
                            else
                                esc_mode = MODE_HEX_HI;
                        end
                        default:
                        begin
                            r.byte_valid = 1'b0;
                            r.status     = ST_UNKNOWN;
                        end
                    endcase
                end
                MODE_HEX_HI:
                begin
                    d = nibble_of(c);
                    if (fin)
                        r.status = ST_DANGLING;
                    else
                    begin
                        hi_nib   = d[3:0];
                        hi_bad   = d[4];
                        esc_mode = MODE_HEX_LO;
                    end
                end
                default:
                begin
                    d        = nibble_of(c);
                    esc_mode = MODE_NORMAL;
                    if (hi_bad || d[4])
                        r.status = ST_BAD_HEX;
                    else
                    begin
                        r.out_byte   = {hi_nib, d[3:0]};
                        r.byte_valid = 1'b1;
                    end
                end
            endcase
            if (r.status != ST_OK)
            begin
                failed   = 1'b1;
                esc_mode = MODE_NORMAL;
            end
        end
        if (fin)
            clear_decoder();
        if (r.byte_valid || r.status != ST_OK || fin)
            expected_words.push_back(r);
    endtask

    // queue the buffered string, final flag on its last character
    task automatic flush_string(input bit drain_first);
        pending_word_t p;
        for (int i = 0; i < str_buf.size(); i++)
        begin
            p.word.in_char  = str_buf[i];
            p.word.is_final = (i == str_buf.size() - 1);
            p.drain         = drain_first && (i == 0);
            pending_words.push_back(p);
        end
        str_buf.delete();
    endtask

    task automatic random_string();
        int segs;
        int pick;
        int keep;
        bit drain_now;
        segs = $urandom_range(1, 8);
        for (int s = 0; s < segs; s++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 45)
                str_buf.push_back(8'($urandom_range(0, 255)));
            else if (pick < 75)
            begin
                str_buf.push_back(CHAR_BACKSLASH);
                str_buf.push_back(ESC_LETTERS[$urandom_range(0, 5)]);
            end
            else if (pick < 92)
            begin
                str_buf.push_back(CHAR_BACKSLASH);
                str_buf.push_back(CHAR_X);
                str_buf.push_back(hex_char(4'($urandom_range(0, 15)), 1'($urandom)));
                str_buf.push_back(hex_char(4'($urandom_range(0, 15)), 1'($urandom)));
            end
            else if (pick < 96)
            begin
                str_buf.push_back(CHAR_BACKSLASH);
                str_buf.push_back(CHAR_X);
                if ($urandom_range(0, 1))
                begin
                    str_buf.push_back(non_hex_char());
                    str_buf.push_back(hex_char(4'($urandom_range(0, 15)), 1'($urandom)));
                end
                else
                begin
                    str_buf.push_back(hex_char(4'($urandom_range(0, 15)), 1'($urandom)));
                    str_buf.push_back(non_hex_char());
                end
            end
            else
            begin
                str_buf.push_back(CHAR_BACKSLASH);
                str_buf.push_back(8'($urandom_range(0, 255)));
            end
        end
        // cut some strings short, often mid-escape
        if ($urandom_range(0, 99) < 8)
        begin
            keep = $urandom_range(1, str_buf.size());
            while (str_buf.size() > keep)
                void'(str_buf.pop_back());
        end
        drain_now = !drain_placed && (pending_words.size() >= DRAIN_AT);
        if (drain_now)
            drain_placed = 1'b1;
        flush_string(drain_now);
    endtask

    // driver and decoder copy
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ch.valid    <= 1'b0;
            in_ch.in_char  <= 8'd0;
            in_ch.is_final <= 1'b0;
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
            begin
                decode_char(in_ch.in_char, in_ch.is_final);
                n_sent++;
            end
            if (!in_ch.valid || in_ch.ready)
            begin
                if (pending_words.size() != 0
                    && (calm || $urandom_range(0, 99) >= IDLE_PCT)
                    && !(pending_words[0].drain && expected_words.size() != 0))
                begin
                    next_word       = pending_words.pop_front();
                    in_ch.valid    <= 1'b1;
                    in_ch.in_char  <= next_word.word.in_char;
                    in_ch.is_final <= next_word.word.is_final;
                end
                else
                begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                if (expected_words.size() == 0)
                begin
                    $error("unexpected word: out_byte %0h byte_valid %0b status %0d done %0b",
                           out_ch.out_byte, out_ch.byte_valid, out_ch.status,
                           out_ch.string_done);
                    errors++;
                end
                else
                begin
                    head_word = expected_words.pop_front();
                    if (out_ch.out_byte !== head_word.out_byte)
                    begin
                        $error("out_byte: expected %0h, actual %0h",
                               head_word.out_byte, out_ch.out_byte);
                        errors++;
                    end
                    if (out_ch.byte_valid !== head_word.byte_valid)
                    begin
                        $error("byte_valid: expected %0b, actual %0b",
                               head_word.byte_valid, out_ch.byte_valid);
                        errors++;
                    end
                    if (out_ch.status !== head_word.status)
                    begin
                        $error("status: expected %0d, actual %0d",
                               head_word.status, out_ch.status);
                        errors++;
                    end
                    if (out_ch.string_done !== head_word.string_done)
                    begin
                        $error("string_done: expected %0b, actual %0b",
                               head_word.string_done, out_ch.string_done);
                        errors++;
                    end
                end
            end
            out_ch.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // watchdog on cycles with no word moving on either channel
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        clk            = 1'b0;
        rst_n          = 1'b0;
        in_ch.valid    = 1'b0;
        in_ch.in_char  = 8'd0;
        in_ch.is_final = 1'b0;
        out_ch.ready   = 1'b0;
        n_sent         = 0;
        errors         = 0;
        drain_placed   = 1'b0;
        clear_decoder();

        // extremes, bad high digit, final after error
        str_buf = '{8'hff, CHAR_BACKSLASH, CHAR_X, 8'h67, CHAR_ZERO, 8'h00};
        flush_string(1'b0);
        // every simple escape, last one on the final character
        str_buf = '{CHAR_BACKSLASH, CHAR_BACKSLASH, CHAR_BACKSLASH, CHAR_DQUOTE,
                    CHAR_BACKSLASH, CHAR_R, CHAR_BACKSLASH, CHAR_N,
                    CHAR_BACKSLASH, CHAR_ZERO, CHAR_BACKSLASH, CHAR_T};
        flush_string(1'b0);
        // hex escape, mixed case
        str_buf = '{CHAR_BACKSLASH, CHAR_X, 8'h61, 8'h46};
        flush_string(1'b0);
        // dangling after backslash, after x, after first digit
        str_buf = '{CHAR_BACKSLASH};
        flush_string(1'b0);
        str_buf = '{CHAR_BACKSLASH, CHAR_X};
        flush_string(1'b0);
        str_buf = '{CHAR_BACKSLASH, CHAR_X, 8'h34};
        flush_string(1'b0);
        // unknown escape then final
        str_buf = '{CHAR_BACKSLASH, 8'h71, 8'h61};
        flush_string(1'b0);

        while (pending_words.size() < RAND_ITEMS + 30)
            random_string();

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_words.size() != 0 || in_ch.valid)
            @(posedge clk);
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (errors == 0 && expected_words.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ----- sim.f -----
hdl/sed_pkg.sv
hdl/sed_if.sv
hdl/string_escape_decoder_unit.sv
hdl/sed_checker.sv
verif/tb_top.sv
